/* rtl/disc_pair_elastic_collision_assert.svh */
// assertion macros for the disc pair collision block
`ifndef DISC_PAIR_ELASTIC_COLLISION_ASSERT_SVH
`define DISC_PAIR_ELASTIC_COLLISION_ASSERT_SVH

`ifndef SYNTHESIS
`define DPEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DPEC_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPEC_ASSERT(lbl, prop, msg)
`define DPEC_ASSERT_NORST(lbl, prop, msg)
`endif

`endif

/* rtl/dpec_pkg.sv */
package dpec_pkg;

  localparam int SW = 68;
  localparam int QW = 15;
  localparam int NSRCH = 15;

  typedef struct packed {
    logic signed [19:0] x1;
    logic signed [19:0] y1;
    logic signed [15:0] vx1;
    logic signed [15:0] vy1;
    logic signed [19:0] x2;
    logic signed [19:0] y2;
    logic signed [15:0] vx2;
    logic signed [15:0] vy2;
  } pass_t;

  typedef struct packed {
    logic [QW-1:0]        q;
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] u;
    logic [63:0]          lim;
  } srch_t;

  typedef struct packed {
    pass_t       p;
    logic        hit;
    logic        same;
    logic        sx;
    logic        sy;
    logic [33:0] d;
  } mid_t;

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) r = 16'sh7fff;
    else if (v < -24'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [23:0] v);
    logic signed [19:0] r;
    if (v > 24'sd524287) r = 20'sh7ffff;
    else if (v < -24'sd524288) r = 20'sh80000;
    else r = v[19:0];
    return r;
  endfunction

endpackage

/* rtl/dpec_nstep.sv */
module dpec_nstep #(
  parameter int BIT = 14
) (
  input  dpec_pkg::srch_t si,
  input  logic [33:0]     d,
  output dpec_pkg::srch_t so
);

  logic signed [dpec_pkg::SW-1:0] dext;
  logic signed [dpec_pkg::SW-1:0] cand_s;
  logic                           take;

  // (2q-1)^2*d tracked incrementally, (2q-1)*d alongside
  assign dext   = $signed({{(dpec_pkg::SW-34){1'b0}}, d});
  assign cand_s = si.s + (si.u <<< (BIT + 2)) + (dext <<< (2 * BIT + 2));
  assign take   = !si.q[dpec_pkg::QW-1] &&
                  (cand_s <= $signed({{(dpec_pkg::SW-64){1'b0}}, si.lim}));

  always_comb begin
    so = si;
    if (take) begin
      so.q = si.q | (dpec_pkg::QW'(1) << BIT);
      so.s = cand_s;
      so.u = si.u + (dext <<< (BIT + 1));
    end
  end

endmodule

/* rtl/disc_pair_elastic_collision.sv */
// channel  direction  handshake           payload
// in_      input      in_valid/in_stall   two discs: centre, velocity, radius
// out_     output     out_valid/out_stall hit, same_centre, updated discs
// one word accepted per cycle while in_stall is low, through a fixed pipeline
// the normal is found by a 15-stage bit search, one stage per quotient bit
// synchronous active-low reset clears the stage valid bits only
// a stall holds each full stage from the output back to the first empty one; stages behind it keep filling
`include "disc_pair_elastic_collision_assert.svh"

module disc_pair_elastic_collision (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [19:0] in_first_pos_x,
  input  logic signed [19:0] in_first_pos_y,
  input  logic signed [15:0] in_first_vel_x,
  input  logic signed [15:0] in_first_vel_y,
  input  logic [15:0]        in_first_rad,
  input  logic signed [19:0] in_second_pos_x,
  input  logic signed [19:0] in_second_pos_y,
  input  logic signed [15:0] in_second_vel_x,
  input  logic signed [15:0] in_second_vel_y,
  input  logic [15:0]        in_second_rad,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic               out_same_centre,
  output logic signed [19:0] out_new_first_x,
  output logic signed [19:0] out_new_first_y,
  output logic signed [15:0] out_new_first_vx,
  output logic signed [15:0] out_new_first_vy,
  output logic signed [19:0] out_new_second_x,
  output logic signed [19:0] out_new_second_y,
  output logic signed [15:0] out_new_second_vx,
  output logic signed [15:0] out_new_second_vy
);

  localparam int NS = 8 + dpec_pkg::NSRCH;
  localparam int SB = 5;

  logic [NS:1]   v_r;
  logic [NS+1:1] rdy;

  always_comb begin
    rdy[NS+1] = !out_stall;
    for (int i = NS; i >= 1; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = v_r[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) v_r[1] <= in_valid;
      for (int i = 2; i <= NS; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // stage 1: input word
  dpec_pkg::pass_t s1_p_r;
  logic [15:0]     s1_r1_r, s1_r2_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_p_r.x1  <= in_first_pos_x;
      s1_p_r.y1  <= in_first_pos_y;
      s1_p_r.vx1 <= in_first_vel_x;
      s1_p_r.vy1 <= in_first_vel_y;
      s1_p_r.x2  <= in_second_pos_x;
      s1_p_r.y2  <= in_second_pos_y;
      s1_p_r.vx2 <= in_second_vel_x;
      s1_p_r.vy2 <= in_second_vel_y;
      s1_r1_r    <= in_first_rad;
      s1_r2_r    <= in_second_rad;
    end
  end

  // stage 2: differences
  dpec_pkg::pass_t    s2_p_r;
  logic signed [20:0] s2_dx_r, s2_dy_r;
  logic [16:0]        s2_rs_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_p_r  <= s1_p_r;
      s2_dx_r <= 21'(s1_p_r.x1) - 21'(s1_p_r.x2);
      s2_dy_r <= 21'(s1_p_r.y1) - 21'(s1_p_r.y2);
      s2_rs_r <= 17'(s1_r1_r) + 17'(s1_r2_r);
    end
  end

  // stage 3: squares and magnitudes
  dpec_pkg::pass_t    s3_p_r;
  logic [40:0]        s3_dx2_r, s3_dy2_r;
  logic [33:0]        s3_rs2_r;
  logic [20:0]        s3_mx_r, s3_my_r;
  logic               s3_sx_r, s3_sy_r;
  logic signed [41:0] dx2_w, dy2_w;
  logic [33:0]        rs2_w;

  assign dx2_w = s2_dx_r * s2_dx_r;
  assign dy2_w = s2_dy_r * s2_dy_r;
  assign rs2_w = s2_rs_r * s2_rs_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_p_r   <= s2_p_r;
      s3_dx2_r <= dx2_w[40:0];
      s3_dy2_r <= dy2_w[40:0];
      s3_rs2_r <= rs2_w;
      s3_mx_r  <= s2_dx_r[20] ? 21'(-s2_dx_r) : 21'(s2_dx_r);
      s3_my_r  <= s2_dy_r[20] ? 21'(-s2_dy_r) : 21'(s2_dy_r);
      s3_sx_r  <= s2_dx_r[20];
      s3_sy_r  <= s2_dy_r[20];
    end
  end

  // stage 4: distance, overlap, search setup
  dpec_pkg::mid_t  s4_m_r;
  dpec_pkg::srch_t s4_x_r, s4_y_r;
  logic [41:0]     d_w, mx2_w, my2_w;
  logic            ovl_w, same_w;
  logic signed [dpec_pkg::SW-1:0] dinit_w;

  assign d_w     = {1'b0, s3_dx2_r} + {1'b0, s3_dy2_r};
  assign ovl_w   = d_w < {8'b0, s3_rs2_r};
  assign same_w  = ovl_w && (d_w == '0);
  assign mx2_w   = s3_mx_r * s3_mx_r;
  assign my2_w   = s3_my_r * s3_my_r;
  assign dinit_w = $signed({{(dpec_pkg::SW-34){1'b0}}, d_w[33:0]});

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_m_r.p    <= s3_p_r;
      s4_m_r.hit  <= ovl_w && !same_w;
      s4_m_r.same <= same_w;
      s4_m_r.sx   <= s3_sx_r;
      s4_m_r.sy   <= s3_sy_r;
      s4_m_r.d    <= d_w[33:0];
      s4_x_r.q    <= '0;
      s4_x_r.s    <= dinit_w;
      s4_x_r.u    <= -dinit_w;
      s4_x_r.lim  <= {mx2_w[33:0], 30'b0};
      s4_y_r.q    <= '0;
      s4_y_r.s    <= dinit_w;
      s4_y_r.u    <= -dinit_w;
      s4_y_r.lim  <= {my2_w[33:0], 30'b0};
    end
  end

  // bit search for the normal, msb first
  dpec_pkg::mid_t  sm_r [dpec_pkg::NSRCH];
  dpec_pkg::srch_t sx_r [dpec_pkg::NSRCH];
  dpec_pkg::srch_t sy_r [dpec_pkg::NSRCH];

  for (genvar j = 0; j < dpec_pkg::NSRCH; j++) begin : g_srch
    dpec_pkg::mid_t  mi;
    dpec_pkg::srch_t xi, yi, xn, yn;

    if (j == 0) begin : g_first
      assign mi = s4_m_r;
      assign xi = s4_x_r;
      assign yi = s4_y_r;
    end else begin : g_next
      assign mi = sm_r[j-1];
      assign xi = sx_r[j-1];
      assign yi = sy_r[j-1];
    end

    dpec_nstep #(.BIT(dpec_pkg::NSRCH - 1 - j)) u_nx (.si(xi), .d(mi.d), .so(xn));
    dpec_nstep #(.BIT(dpec_pkg::NSRCH - 1 - j)) u_ny (.si(yi), .d(mi.d), .so(yn));

    always_ff @(posedge clk) begin
      if (rdy[SB+j]) begin
        sm_r[j] <= mi;
        sx_r[j] <= xn;
        sy_r[j] <= yn;
      end
    end
  end

  // normal speed products
  localparam int S20 = SB + dpec_pkg::NSRCH;
  dpec_pkg::mid_t     sl_w;
  dpec_pkg::pass_t    s20_p_r;
  logic               s20_hit_r, s20_same_r;
  logic signed [15:0] s20_nx_r, s20_ny_r, nx_w, ny_w;
  logic signed [31:0] s20_m1_r, s20_m2_r, s20_m3_r, s20_m4_r;

  assign sl_w = sm_r[dpec_pkg::NSRCH-1];
  assign nx_w = sl_w.sx ? -$signed({1'b0, sx_r[dpec_pkg::NSRCH-1].q})
                        :  $signed({1'b0, sx_r[dpec_pkg::NSRCH-1].q});
  assign ny_w = sl_w.sy ? -$signed({1'b0, sy_r[dpec_pkg::NSRCH-1].q})
                        :  $signed({1'b0, sy_r[dpec_pkg::NSRCH-1].q});

  always_ff @(posedge clk) begin
    if (rdy[S20]) begin
      s20_p_r    <= sl_w.p;
      s20_hit_r  <= sl_w.hit;
      s20_same_r <= sl_w.same;
      s20_nx_r   <= nx_w;
      s20_ny_r   <= ny_w;
      s20_m1_r   <= sl_w.p.vx1 * nx_w;
      s20_m2_r   <= sl_w.p.vy1 * ny_w;
      s20_m3_r   <= sl_w.p.vx2 * nx_w;
      s20_m4_r   <= sl_w.p.vy2 * ny_w;
    end
  end

  // normal speed of the second disc minus that of the first
  dpec_pkg::pass_t    s21_p_r;
  logic               s21_hit_r, s21_same_r;
  logic signed [15:0] s21_nx_r, s21_ny_r;
  logic signed [33:0] s21_dp_r;

  always_ff @(posedge clk) begin
    if (rdy[S20+1]) begin
      s21_p_r    <= s20_p_r;
      s21_hit_r  <= s20_hit_r;
      s21_same_r <= s20_same_r;
      s21_nx_r   <= s20_nx_r;
      s21_ny_r   <= s20_ny_r;
      s21_dp_r   <= (34'(s20_m3_r) + 34'(s20_m4_r)) - (34'(s20_m1_r) + 34'(s20_m2_r));
    end
  end

  // exchange along the normal
  dpec_pkg::pass_t    s22_p_r;
  logic               s22_hit_r, s22_same_r;
  logic signed [15:0] s22_nx_r, s22_ny_r;
  logic signed [49:0] s22_rx_r, s22_ry_r;

  always_ff @(posedge clk) begin
    if (rdy[S20+2]) begin
      s22_p_r    <= s21_p_r;
      s22_hit_r  <= s21_hit_r;
      s22_same_r <= s21_same_r;
      s22_nx_r   <= s21_nx_r;
      s22_ny_r   <= s21_ny_r;
      s22_rx_r   <= s21_dp_r * s21_nx_r;
      s22_ry_r   <= s21_dp_r * s21_ny_r;
    end
  end

  // rounding, update, saturation on a hit; discs passed through unchanged otherwise
  logic signed [49:0] trx_w, try_w;
  logic signed [21:0] rx_w, ry_w;
  logic signed [16:0] tpx_w, tpy_w;
  logic signed [10:0] px_w, py_w;

  assign trx_w = s22_rx_r + 50'sd134217728;
  assign try_w = s22_ry_r + 50'sd134217728;
  assign rx_w  = $signed(trx_w[49:28]);
  assign ry_w  = $signed(try_w[49:28]);
  assign tpx_w = 17'(s22_nx_r) + 17'sd32;
  assign tpy_w = 17'(s22_ny_r) + 17'sd32;
  assign px_w  = $signed(tpx_w[16:6]);
  assign py_w  = $signed(tpy_w[16:6]);

  always_ff @(posedge clk) begin
    if (rdy[NS]) begin
      out_hit         <= s22_hit_r;
      out_same_centre <= s22_same_r;
      if (s22_hit_r) begin
        out_new_first_vx  <= dpec_pkg::sat16(24'(s22_p_r.vx1) + 24'(rx_w));
        out_new_first_vy  <= dpec_pkg::sat16(24'(s22_p_r.vy1) + 24'(ry_w));
        out_new_second_vx <= dpec_pkg::sat16(24'(s22_p_r.vx2) - 24'(rx_w));
        out_new_second_vy <= dpec_pkg::sat16(24'(s22_p_r.vy2) - 24'(ry_w));
        out_new_first_x   <= dpec_pkg::sat20(24'(s22_p_r.x1) + 24'(px_w));
        out_new_first_y   <= dpec_pkg::sat20(24'(s22_p_r.y1) + 24'(py_w));
        out_new_second_x  <= dpec_pkg::sat20(24'(s22_p_r.x2) - 24'(px_w));
        out_new_second_y  <= dpec_pkg::sat20(24'(s22_p_r.y2) - 24'(py_w));
      end else begin
        out_new_first_vx  <= s22_p_r.vx1;
        out_new_first_vy  <= s22_p_r.vy1;
        out_new_second_vx <= s22_p_r.vx2;
        out_new_second_vy <= s22_p_r.vy2;
        out_new_first_x   <= s22_p_r.x1;
        out_new_first_y   <= s22_p_r.y1;
        out_new_second_x  <= s22_p_r.x2;
        out_new_second_y  <= s22_p_r.y2;
      end
    end
  end

  `DPEC_ASSERT(a_stall_full, in_stall |-> (v_r == '1) && out_stall, "input stalled with a free stage")
  `DPEC_ASSERT(a_flags, out_valid |-> $onehot0({out_hit, out_same_centre}), "hit and same centre together")
  `DPEC_ASSERT_NORST(a_rst_empty, !rst_n |=> !out_valid, "output valid right after reset")

endmodule
